// ===== hw/rtl/acd_pkg.sv =====
package acd_pkg;

	localparam int WINDOW = 3;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	localparam int DIST_W = 13;
	localparam int SUM_W = DIST_W + $clog2(WINDOW);
	localparam int SPD_W = 11;
	localparam int SPD2_W = DIST_W + 3;
	localparam int MAG_W = 10;
	localparam int SQ_W = 2 * MAG_W;
	localparam int DEC_W = 10;
	localparam int DEC2_W = DEC_W + 1;
	localparam int PROD_W = DEC2_W + DIST_W;

	localparam int DVD_W = SQ_W;
	localparam int DVS_W = DEC2_W;
	localparam int ITER_W = $clog2(DVD_W + 1);

	localparam int SPEED_FLOOR = -1000;
	localparam logic [DIST_W-1:0] STOP_SAT = {DIST_W{1'b1}};
	localparam logic [DEC_W-1:0] DECEL_RST = DEC_W'(100);

	localparam int TDATA_IN_W = 16;
	localparam int TDATA_OUT_W = 40;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_DECEL = 1'b1;

	typedef enum logic [1:0] {
		SC_NONE,
		SC_POSSIBLE,
		SC_DETECTED
	} scen_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_SUM,
		SQ_AVG_GO,
		SQ_AVG_WAIT,
		SQ_SPEED,
		SQ_MUL,
		SQ_STOP_GO,
		SQ_STOP_WAIT,
		SQ_DONE
	} seq_t;

	typedef struct packed {
		logic accept;
		logic sum_step;
		logic div_start;
		logic div_sel_stop;
		logic avg_load;
		logic speed_load;
		logic mul_load;
		logic stop_load;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic sum_last;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/acd_div.sv =====
module acd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [acd_pkg::DVD_W-1:0]  dividend,
	input  logic [acd_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [acd_pkg::DVD_W-1:0]  quotient
);
	import acd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W:0]    trial;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DVD_W);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DVS_W]) begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/acd_datapath.sv =====
module acd_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  acd_pkg::dp_cmd_t                cmd,
	output acd_pkg::dp_status_t             status,
	input  logic [acd_pkg::TDATA_IN_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [acd_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [acd_pkg::DEC_W-1:0]       cfg_wdata
);
	import acd_pkg::*;

	logic                    en_q;
	logic [DEC_W-1:0]        decel_q;
	logic [DIST_W-1:0]       win_q [WINDOW];
	logic [SLOT_W-1:0]       slot_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    restart_q;
	scen_t                   scen_q;
	scen_t                   scen_next;
	logic [DIST_W-1:0]       prior_q;
	logic [DIST_W-1:0]       avg_q;
	logic signed [SPD_W-1:0] spd_q;
	logic [SQ_W-1:0]         sq_q;
	logic [PROD_W-1:0]       prod_q;
	logic [DIST_W-1:0]       stop_q;
	logic                    out_valid_q;
	logic [TDATA_OUT_W-1:0]  out_data_q;

	logic [DEC2_W-1:0]        decel2;
	logic signed [DIST_W+1:0] diff;
	logic signed [SPD2_W-1:0] spd2;
	logic signed [SPD_W-1:0]  spd_new;
	logic signed [SPD_W-1:0]  neg_spd;
	logic [MAG_W-1:0]         mag;
	logic                     div_done;
	logic [DVD_W-1:0]         quo;
	logic [DVD_W-1:0]         dvd;
	logic [DVS_W-1:0]         dvs;
	logic [DIST_W-1:0]        dist_in;

	assign dist_in = s_tdata[DIST_W-1:0];
	assign decel2 = (decel_q == '0) ? DEC2_W'(2) : {decel_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			decel_q <= DECEL_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ENABLE: en_q <= cfg_wdata[0];
				CFG_DECEL:  decel_q <= cfg_wdata;
				default:    en_q <= en_q;
			endcase
		end
	end

	// window, ring slot, scenario and previous average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
			slot_q <= '0;
			scen_q <= SC_NONE;
			prior_q <= '0;
		end else begin
			if (cmd.accept && !status.skip) begin
				win_q[slot_q] <= dist_in;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.finish) begin
				if (restart_q) begin
					scen_q <= SC_NONE;
				end else if (scen_q != SC_DETECTED) begin
					scen_q <= scen_next;
					prior_q <= avg_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			restart_q <= s_tuser;
			idx_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.sum_step) begin
			idx_q <= idx_q + 1'b1;
			sum_q <= sum_q + SUM_W'(win_q[idx_q]);
			if (win_q[idx_q] != '0) cnt_q <= cnt_q + 1'b1;
		end
	end

	assign dvd = cmd.div_sel_stop ? sq_q : DVD_W'(sum_q);
	assign dvs = cmd.div_sel_stop ? decel2 : DVS_W'(cnt_q);

	acd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		diff = $signed({2'b00, avg_q}) - $signed({2'b00, prior_q});
		spd2 = {diff, 1'b0};
		if (spd2 > 0 || spd2 < $signed(SPD2_W'(SPEED_FLOOR))) spd_new = '0;
		else spd_new = spd2[SPD_W-1:0];
		neg_spd = -spd_q;
		mag = neg_spd[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.avg_load) avg_q <= (cnt_q == '0) ? '0 : quo[DIST_W-1:0];
		if (cmd.speed_load) spd_q <= spd_new;
		if (cmd.mul_load) begin
			sq_q <= mag * mag;
			prod_q <= decel2 * avg_q;
		end
		if (cmd.stop_load) stop_q <= (quo > DVD_W'(STOP_SAT)) ? STOP_SAT : quo[DIST_W-1:0];
	end

	always_comb begin
		scen_next = scen_q;
		if (en_q) begin
			case (scen_q)
				SC_NONE: begin
					if (avg_q < prior_q && spd_q[SPD_W-1]) scen_next = SC_POSSIBLE;
				end
				SC_POSSIBLE: begin
					if (avg_q > DIST_W'(1) && PROD_W'(sq_q) >= prod_q)
						scen_next = SC_DETECTED;
					else if (avg_q >= prior_q || !spd_q[SPD_W-1] || avg_q == '0)
						scen_next = SC_NONE;
				end
				default: scen_next = SC_NONE;
			endcase
		end
	end

	// output register: scenario, average, speed, stop from bit 0 up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (restart_q)
				out_data_q <= {1'b0, DIST_W'(0), SPD_W'(0), prior_q, SC_NONE};
			else if (scen_q == SC_DETECTED)
				out_data_q <= {1'b0, DIST_W'(0), SPD_W'(0), prior_q, SC_DETECTED};
			else
				out_data_q <= {1'b0, stop_q, spd_q, avg_q, scen_next};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign status.skip = s_tuser || (scen_q == SC_DETECTED);
	assign status.sum_last = (idx_q == SLOT_W'(WINDOW - 1));
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || m_tready;

	a_frozen_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !s_tuser && scen_q == SC_DETECTED |=> $stable(slot_q))
		else $error("window advanced while detection is frozen");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result overwrote an untaken result");

	a_speed_sign: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (m_tdata[25] || m_tdata[25:15] == '0))
		else $error("positive speed in result");

endmodule

// ===== hw/rtl/acd_ctrl.sv =====
module acd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  acd_pkg::dp_status_t status,
	output acd_pkg::dp_cmd_t    cmd
);
	import acd_pkg::*;

	seq_t state_q;
	seq_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SQ_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (s_tvalid) state_next = status.skip ? SQ_DONE : SQ_SUM;
			end
			SQ_SUM:       if (status.sum_last) state_next = SQ_AVG_GO;
			SQ_AVG_GO:    state_next = SQ_AVG_WAIT;
			SQ_AVG_WAIT:  if (status.div_done) state_next = SQ_SPEED;
			SQ_SPEED:     state_next = SQ_MUL;
			SQ_MUL:       state_next = SQ_STOP_GO;
			SQ_STOP_GO:   state_next = SQ_STOP_WAIT;
			SQ_STOP_WAIT: if (status.div_done) state_next = SQ_DONE;
			SQ_DONE:      if (status.out_free) state_next = SQ_IDLE;
			default:      state_next = SQ_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			SQ_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
			end
			SQ_SUM:       cmd.sum_step = 1'b1;
			SQ_AVG_GO:    cmd.div_start = 1'b1;
			SQ_AVG_WAIT:  cmd.avg_load = status.div_done;
			SQ_SPEED:     cmd.speed_load = 1'b1;
			SQ_MUL:       cmd.mul_load = 1'b1;
			SQ_STOP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_stop = 1'b1;
			end
			SQ_STOP_WAIT: begin
				cmd.div_sel_stop = 1'b1;
				cmd.stop_load = status.div_done;
			end
			SQ_DONE:      cmd.finish = status.out_free;
			default:      cmd = '0;
		endcase
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == SQ_AVG_WAIT || state_q == SQ_STOP_WAIT))
		else $error("divider finished outside a wait state");

	a_skip_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && status.skip |=> state_q == SQ_DONE)
		else $error("restart or frozen transaction entered the sample path");

endmodule

// ===== hw/rtl/approach_collision_detector.sv =====
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tdata: distance_mm; tuser: req_type
// m_      | out | m_tvalid/m_tready | tdata: scenario, avg_distance_mm,
//         |     |                   |        approach_speed, stopping_mm
// cfg_    | in  | cfg_we            | cfg_addr 0 enable, 1 decel; cfg_wdata
//
// A sample transaction makes two passes through the shared 20-bit radix-2 divider
// (average, stopping distance).
// Restart and frozen transactions skip the window sum and the divider.
// A new transaction is accepted while the previous result waits in the output register.
// Reset clears the window, the previous average and the scenario state at once.
module approach_collision_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [acd_pkg::TDATA_IN_W-1:0]  s_tdata,  // [12:0] distance_mm
	input  logic                            s_tuser,  // [0] req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] scenario, [14:2] avg_distance_mm, [25:15] approach_speed, [38:26] stopping_mm
	output logic [acd_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [acd_pkg::DEC_W-1:0]       cfg_wdata
);
	import acd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	acd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	acd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// ===== verif/approach_collision_detector_tb.sv =====
`timescale 1ns / 1ps

module approach_collision_detector_tb;
	import acd_pkg::*;

	typedef struct packed {
		logic              restart;
		logic [DIST_W-1:0] dist_mm;
	} req_t;

	typedef struct packed {
		scen_t                    scen;
		logic [DIST_W-1:0]        avg;
		logic signed [SPD_W-1:0]  speed;
		logic [DIST_W-1:0]        stop;
	} resp_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic                   cfg_addr = CFG_ENABLE;
	logic [DEC_W-1:0]       cfg_wdata = '0;

	req_t  samples_pending[$];
	resp_t results_due[$];
	logic  in_taken = 1'b0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    error_count = 0;
	int    items_queued = 0;

	// detector state as the block should hold it
	logic [DIST_W-1:0] win_mm[WINDOW];
	int                win_slot;
	int                last_avg;
	scen_t             track_state;
	logic              model_enable;
	logic [DEC_W-1:0]  model_decel;

	approach_collision_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic resp_t advance_detector_model(req_t r);
		resp_t res;
		int    sum, cnt, avg, speed, decel, sq, stop, i;
		res.scen = SC_NONE;
		res.avg = DIST_W'(last_avg);
		res.speed = '0;
		res.stop = '0;
		if (r.restart) begin
			track_state = SC_NONE;
			return res;
		end
		// frozen after detection until a restart
		if (track_state == SC_DETECTED) begin
			res.scen = SC_DETECTED;
			return res;
		end
		win_mm[win_slot] = r.dist_mm;
		win_slot = (win_slot + 1) % WINDOW;
		sum = 0;
		cnt = 0;
		for (i = 0; i < WINDOW; i++) begin
			if (win_mm[i] != 0) begin
				sum += win_mm[i];
				cnt++;
			end
		end
		avg = (cnt != 0) ? sum / cnt : 0;
		speed = 2 * (avg - last_avg);
		if (speed > 0 || speed < SPEED_FLOOR)
			speed = 0;
		decel = (model_decel == 0) ? 1 : model_decel;
		sq = speed * speed;
		stop = sq / (2 * decel);
		if (stop > STOP_SAT)
			stop = STOP_SAT;
		if (model_enable) begin
			case (track_state)
				SC_NONE: begin
					if (avg < last_avg && speed < 0)
						track_state = SC_POSSIBLE;
				end
				SC_POSSIBLE: begin
					if (avg > 1 && sq >= 2 * decel * avg)
						track_state = SC_DETECTED;
					else if (avg >= last_avg || speed >= 0 || avg == 0)
						track_state = SC_NONE;
				end
				default: track_state = SC_NONE;
			endcase
		end
		last_avg = avg;
		res.scen = track_state;
		res.avg = DIST_W'(avg);
		res.speed = SPD_W'(speed);
		res.stop = DIST_W'(stop);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_field(string name, logic signed [15:0] got, logic signed [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// stream driver: new transaction at the falling edge once the previous one was taken
	always @(negedge clk) begin : drive_stream
		req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || in_taken) begin
				if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = samples_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.restart;
					s_tdata <= TDATA_IN_W'(nxt.dist_mm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : watch_stream
		resp_t want;
		req_t  seen;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %h", m_tdata));
				end else begin
					want = results_due.pop_front();
					compare_field("scenario", m_tdata[1:0], want.scen);
					compare_field("avg_distance_mm", m_tdata[14:2], want.avg);
					compare_field("approach_speed", $signed(m_tdata[25:15]), want.speed);
					compare_field("stopping_mm", m_tdata[38:26], want.stop);
				end
			end
			if (s_tvalid && s_tready) begin
				seen.restart = s_tuser;
				seen.dist_mm = s_tdata[DIST_W-1:0];
				results_due.push_back(advance_detector_model(seen));
			end
		end
		in_taken <= arst_n && s_tvalid && s_tready;
	end

	task automatic write_reg(logic addr, logic [DEC_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == CFG_ENABLE)
			model_enable = value[0];
		else
			model_decel = value;
	endtask

	task automatic wait_quiet();
		while (samples_pending.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic queue_item(logic restart, int dist_val);
		req_t r;
		r.restart = restart;
		r.dist_mm = DIST_W'(dist_val);
		samples_pending.push_back(r);
		items_queued++;
	endtask

	// steady target, then a closing run; occasional dropouts read as zero
	task automatic queue_approach();
		int pos, step, len, k, pick;
		pos = $urandom_range(8191, 300);
		pick = $urandom_range(9);
		if (pick < 3)
			step = $urandom_range(40, 1);
		else if (pick < 9)
			step = $urandom_range(500, 40);
		else
			step = $urandom_range(1500, 500);
		len = $urandom_range(12, 3);
		repeat ($urandom_range(3, 1)) queue_item(1'b0, pos);
		for (k = 0; k < len && pos > step; k++) begin
			pos -= step;
			queue_item(1'b0, ($urandom_range(9) == 0) ? 0 : pos);
		end
		if ($urandom_range(3) != 0)
			queue_item(1'b1, $urandom_range(8191));
	endtask

	task automatic queue_random(int n);
		int target, pick;
		target = items_queued + n;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 65)
				queue_approach();
			else if (pick < 88)
				repeat ($urandom_range(4, 1))
					queue_item(1'b0, ($urandom_range(7) == 0) ? 0 : $urandom_range(8191));
			else
				queue_item(1'b1, $urandom_range(8191));
		end
	endtask

	task automatic run_phase(logic en, int decel, int idle, int stall, int n);
		write_reg(CFG_ENABLE, DEC_W'(en));
		write_reg(CFG_DECEL, DEC_W'(decel));
		send_idle_pct = idle;
		recv_stall_pct = stall;
		queue_random(n);
		wait_quiet();
	endtask

	initial begin
		for (int i = 0; i < WINDOW; i++)
			win_mm[i] = '0;
		win_slot = 0;
		last_avg = 0;
		track_state = SC_NONE;
		model_enable = 1'b0;
		model_decel = DECEL_RST;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_ENABLE, DEC_W'(1));
		write_reg(CFG_DECEL, DEC_W'(100));
		queue_item(1'b0, 0);            // empty window averages to zero
		repeat (3) queue_item(1'b0, 8191);
		queue_item(1'b0, 1);            // drop steeper than the speed floor
		queue_item(1'b1, 8191);
		repeat (2) queue_item(1'b0, 1);
		queue_item(1'b0, 1);
		repeat (3) queue_item(1'b0, 0);
		repeat (3) queue_item(1'b0, 3000);
		queue_item(1'b0, 2600);         // idle -> possible
		queue_item(1'b0, 2200);
		queue_item(1'b0, 1800);         // stopping distance exceeded
		queue_item(1'b0, 1500);         // frozen
		queue_item(1'b1, 0);
		queue_item(1'b0, 5000);         // receding, speed clipped to zero
		wait_quiet();

		run_phase(1'b1, 100, 0, 0, 285);
		run_phase(1'b1, 1, 51, 0, 285);
		run_phase(1'b0, 1000, 0, 51, 140);
		run_phase(1'b1, $urandom_range(999, 2), 0, 51, 145);
		run_phase(1'b1, 0, 30, 30, 285);
		run_phase(1'b1, 1023, 0, 0, 285);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
